### design/sha_pkg.sv
// shared types and constants of the sha-256 stream hasher
package sha_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenBytes   = 8;

   typedef logic [31:0] word_type;

   // one queued block command from front to back
   typedef struct packed {
      logic [511:0] block;
      logic         final_block;
   } blk_cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUND,
      BK_ADD,
      BK_EMIT
   } back_state_type;

   function automatic word_type rotr(word_type v, int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic word_type round_k(logic [5:0] idx);
      case (idx)
         6'd0:  round_k = 32'h428A2F98; 6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hB5C0FBCF; 6'd3:  round_k = 32'hE9B5DBA5;
         6'd4:  round_k = 32'h3956C25B; 6'd5:  round_k = 32'h59F111F1;
         6'd6:  round_k = 32'h923F82A4; 6'd7:  round_k = 32'hAB1C5ED5;
         6'd8:  round_k = 32'hD807AA98; 6'd9:  round_k = 32'h12835B01;
         6'd10: round_k = 32'h243185BE; 6'd11: round_k = 32'h550C7DC3;
         6'd12: round_k = 32'h72BE5D74; 6'd13: round_k = 32'h80DEB1FE;
         6'd14: round_k = 32'h9BDC06A7; 6'd15: round_k = 32'hC19BF174;
         6'd16: round_k = 32'hE49B69C1; 6'd17: round_k = 32'hEFBE4786;
         6'd18: round_k = 32'h0FC19DC6; 6'd19: round_k = 32'h240CA1CC;
         6'd20: round_k = 32'h2DE92C6F; 6'd21: round_k = 32'h4A7484AA;
         6'd22: round_k = 32'h5CB0A9DC; 6'd23: round_k = 32'h76F988DA;
         6'd24: round_k = 32'h983E5152; 6'd25: round_k = 32'hA831C66D;
         6'd26: round_k = 32'hB00327C8; 6'd27: round_k = 32'hBF597FC7;
         6'd28: round_k = 32'hC6E00BF3; 6'd29: round_k = 32'hD5A79147;
         6'd30: round_k = 32'h06CA6351; 6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27B70A85; 6'd33: round_k = 32'h2E1B2138;
         6'd34: round_k = 32'h4D2C6DFC; 6'd35: round_k = 32'h53380D13;
         6'd36: round_k = 32'h650A7354; 6'd37: round_k = 32'h766A0ABB;
         6'd38: round_k = 32'h81C2C92E; 6'd39: round_k = 32'h92722C85;
         6'd40: round_k = 32'hA2BFE8A1; 6'd41: round_k = 32'hA81A664B;
         6'd42: round_k = 32'hC24B8B70; 6'd43: round_k = 32'hC76C51A3;
         6'd44: round_k = 32'hD192E819; 6'd45: round_k = 32'hD6990624;
         6'd46: round_k = 32'hF40E3585; 6'd47: round_k = 32'h106AA070;
         6'd48: round_k = 32'h19A4C116; 6'd49: round_k = 32'h1E376C08;
         6'd50: round_k = 32'h2748774C; 6'd51: round_k = 32'h34B0BCB5;
         6'd52: round_k = 32'h391C0CB3; 6'd53: round_k = 32'h4ED8AA4A;
         6'd54: round_k = 32'h5B9CCA4F; 6'd55: round_k = 32'h682E6FF3;
         6'd56: round_k = 32'h748F82EE; 6'd57: round_k = 32'h78A5636F;
         6'd58: round_k = 32'h84C87814; 6'd59: round_k = 32'h8CC70208;
         6'd60: round_k = 32'h90BEFFFA; 6'd61: round_k = 32'hA4506CEB;
         6'd62: round_k = 32'hBEF9A3F7; 6'd63: round_k = 32'hC67178F2;
         default: round_k = 32'h0;
      endcase
   endfunction

   function automatic word_type init_h(logic [2:0] idx);
      case (idx)
         3'd0: init_h = 32'h6A09E667; 3'd1: init_h = 32'hBB67AE85;
         3'd2: init_h = 32'h3C6EF372; 3'd3: init_h = 32'hA54FF53A;
         3'd4: init_h = 32'h510E527F; 3'd5: init_h = 32'h9B05688C;
         3'd6: init_h = 32'h1F83D9AB; 3'd7: init_h = 32'h5BE0CD19;
         default: init_h = 32'h0;
      endcase
   endfunction

endpackage

### design/sha_if.sv
// valid/ready channel interfaces of the hasher
interface sha_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;
   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### design/sha256_stream_hasher_core.sv
// top level of the byte-stream sha-256 hasher
//
// usage: the req channel carries one transaction per message byte, with
// has_byte marking a byte and end_of_message closing the message. the rsp
// channel returns eight digest words, word_index 0 first, last_word on the
// final one. the front end takes one transaction a cycle while it collects
// a 64-byte block and hands full or padded blocks through a two-entry queue
// to the back end, which runs one compression round a cycle, 64 rounds per
// block, between a setup step and a chaining add. bytes are accepted at
// one a cycle until the queue is full or a closing block is pending. after
// end_of_message the digest appears once the final block and any blocks
// queued ahead of it are compressed. while the receiver stalls the back
// end holds the current word and the queue fills, then the front end
// deasserts ready. reset is synchronous and restores the standard initial
// hash values with empty buffers.
module sha256_stream_hasher_core
   import sha_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   sha_req_if.sink  req,
   sha_rsp_if.source rsp
);

   logic        f_valid, f_ready, q_valid, q_ready;
   blk_cmd_type f_cmd, q_cmd;

   sha_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   sha_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cmd)
   );

   sha_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd), .rsp(rsp)
   );

endmodule

### design/sha_front.sv
// front end: collects bytes, pads and issues block commands
module sha_front
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sha_req_if.sink     req,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output blk_cmd_type cmd
);

   logic [511:0] blk_ff, blk_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  total_ff, total_in;
   // second block pending: length block after an overflowing pad or a full last block
   logic         pend_ff, pend_in;
   logic [63:0]  bits_ff, bits_in;
   logic         out_v_ff, out_v_in;
   blk_cmd_type  out_ff, out_in;

   logic [60:0]  tot_b;
   logic [5:0]   pad_pos;
   logic [511:0] padded;
   logic [63:0]  bitlen;
   logic         slot_free;
   logic         acc;

   assign slot_free = !out_v_ff || cmd_ready;
   assign req.ready = slot_free && !pend_ff;
   assign acc       = req.valid && req.ready;
   assign cmd_valid = out_v_ff;
   assign cmd       = out_ff;

   always_comb begin
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      pend_in  = pend_ff;
      bits_in  = bits_ff;
      out_v_in = out_v_ff && !cmd_ready;
      out_in   = out_ff;
      tot_b    = total_ff + 61'(req.has_byte);
      bitlen   = {tot_b, 3'b000};
      pad_pos  = fill_ff;
      padded   = blk_ff;
      if (pend_ff && slot_free) begin
         // length-only closing block
         out_v_in = 1'b1;
         out_in.block = {448'd0, bits_ff};
         out_in.final_block = 1'b1;
         pend_in = 1'b0;
      end else if (acc) begin
         total_in = tot_b;
         if (req.has_byte) begin
            padded[511 - 8 * fill_ff -: 8] = req.data_byte;
            pad_pos = fill_ff + 6'd1;
         end
         if (req.has_byte && fill_ff == 6'd63) begin
            // full block of data
            out_v_in = 1'b1;
            out_in.block = padded;
            out_in.final_block = 1'b0;
            fill_in = 6'd0;
            blk_in = padded;
            if (req.end_of_message) begin
               pend_in = 1'b1;
               bits_in = bitlen;
               out_in.final_block = 1'b0;
            end
         end else if (req.end_of_message) begin
            // 0x80 then zeros after the last byte
            for (int i = 0; i < 64; i++) begin
               if (6'(i) == pad_pos) padded[511 - 8 * i -: 8] = 8'h80;
               else if (6'(i) > pad_pos) padded[511 - 8 * i -: 8] = 8'h00;
            end
            out_v_in = 1'b1;
            out_in.block = padded;
            if (pad_pos >= 6'(BlockBytes - LenBytes)) begin
               out_in.final_block = 1'b0;
               pend_in = 1'b1;
               bits_in = bitlen;
            end else begin
               out_in.block[63:0] = bitlen;
               out_in.final_block = 1'b1;
            end
            fill_in = 6'd0;
            total_in = 61'd0;
         end else begin
            blk_in = padded;
            fill_in = pad_pos;
         end
         if (req.end_of_message) total_in = 61'd0;
      end
   end

   // length block after a full data block starts with 0x80
   logic [511:0] pend_blk;
   assign pend_blk = {8'h80, 440'd0, bits_ff};
   logic pend_mark_ff, pend_mark_in;
   always_comb begin
      pend_mark_in = pend_mark_ff;
      if (acc && req.end_of_message) begin
         pend_mark_in = req.has_byte && fill_ff == 6'd63;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= 6'd0;
         total_ff     <= 61'd0;
         pend_ff      <= 1'b0;
         out_v_ff     <= 1'b0;
         pend_mark_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         out_v_ff     <= out_v_in;
         pend_mark_ff <= pend_mark_in;
      end
      blk_ff  <= blk_in;
      bits_ff <= bits_in;
      if (pend_ff && slot_free && pend_mark_ff) out_ff <= '{block: pend_blk, final_block: 1'b1};
      else out_ff <= out_in;
   end

   // a pending closing block blocks new transactions
   assert property (@(posedge clock) disable iff (reset) pend_ff |-> !req.ready)
      else $error("front accepted while a closing block was pending");
   assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !cmd_ready |=> out_v_ff && $stable(out_ff))
      else $error("stalled block command changed");
   assert property (@(posedge clock) disable iff (reset)
      acc && req.end_of_message |=> fill_ff == 6'd0 && total_ff == 61'd0)
      else $error("message state not cleared at end");

endmodule

### design/sha_fifo.sv
// two-entry queue of block commands between front and back
module sha_fifo
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  blk_cmd_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output blk_cmd_type out_data
);

   blk_cmd_type slot_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  cnt_ff;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (in_valid && in_ready) wr_ff <= !wr_ff;
         if (out_valid && out_ready) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
      end
      if (in_valid && in_ready) slot_ff[wr_ff] <= in_data;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (wr_ff == rd_ff))
      else $error("empty queue with unequal pointers");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (wr_ff == rd_ff))
      else $error("full queue with unequal pointers");

endmodule

### design/sha_back.sv
// back end: 64-round compression, one round a cycle, and digest output
module sha_back
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  blk_cmd_type cmd,
   sha_rsp_if.source   rsp
);

   back_state_type state_ff, state_in;
   word_type       h_ff [8];
   word_type       v_ff [8];
   word_type       w_ff [16];
   logic [5:0]     rnd_ff;
   logic [2:0]     idx_ff;
   logic           fin_ff;

   word_type wt, s0, s1, t1, t2, x15, x2;
   logic round_last, emit_last, take;

   assign take       = state_ff == BK_IDLE && cmd_valid;
   assign round_last = rnd_ff == 6'd63;
   assign emit_last  = idx_ff == 3'd7 && rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (cmd_valid) state_in = BK_ROUND;
         BK_ROUND: if (round_last) state_in = BK_ADD;
         BK_ADD:   state_in = fin_ff ? BK_EMIT : BK_IDLE;
         BK_EMIT:  if (emit_last) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_ready       = state_ff == BK_IDLE;
      rsp.valid       = state_ff == BK_EMIT;
      rsp.digest_word = h_ff[idx_ff];
      rsp.word_index  = idx_ff;
      rsp.last_word   = idx_ff == 3'd7;
   end

   // schedule word and round function
   always_comb begin
      x15 = w_ff[1];
      x2  = w_ff[14];
      s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
      s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
      wt  = w_ff[0];
      t1  = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
            + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(rnd_ff) + wt;
      t2  = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
            + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= 3'd0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_ADD) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end
         if (state_ff == BK_EMIT && rsp.ready) begin
            idx_ff <= idx_ff + 3'd1;
            if (emit_last) begin
               for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
            end
         end
      end
      if (take) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= cmd.block[511 - 32 * i -: 32];
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         fin_ff <= cmd.final_block;
         rnd_ff <= 6'd0;
      end else if (state_ff == BK_ROUND) begin
         // window shifts one word a round
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_ff[0] + s0 + w_ff[9] + s1;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         rnd_ff <= rnd_ff + 6'd1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_ROUND && round_last |=> state_ff == BK_ADD)
      else $error("compression did not end after 64 rounds");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != BK_EMIT |-> idx_ff == 3'd0)
      else $error("word index not reset outside output");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(idx_ff))
      else $error("stalled digest word moved");

endmodule
